// ===== src/kcv_pkg.sv =====
package kcv_pkg;

  localparam int KERNEL_SIZE = 3;
  localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int MAX_WIDTH   = 1024;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int LANES       = 3;

  localparam int PROD_W      = 25;   // 16-bit unsigned pixel times signed 8-bit coefficient
  localparam int ROW_W       = 27;   // sum of three products
  localparam int SUM_W       = 29;   // sum of nine products
  localparam int MAG_W       = SUM_W - 1;
  localparam int DIV_STEPS   = 4;    // quotient bits per divider stage
  localparam int DIV_STAGES  = MAG_W / DIV_STEPS;

  typedef enum logic [2:0] {
    CFG_COEFF_ROW0  = 3'd0,
    CFG_COEFF_ROW1  = 3'd1,
    CFG_COEFF_ROW2  = 3'd2,
    CFG_DIVISOR     = 3'd3,
    CFG_OFFSET      = 3'd4,
    CFG_COLOR_MODE  = 3'd5,
    CFG_IMAGE_WIDTH = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [23:0] pixel_in;
    logic        start_of_frame;
    logic        end_of_frame;
  } in_t;

  typedef struct packed {
    logic [23:0] pixel_out;
    logic        last_out;
  } out_t;

endpackage

// ===== src/kcv_div.sv =====
module kcv_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [7:0]                divisor,
  input  logic [kcv_pkg::MAG_W-1:0] mag_in,
  input  logic                      neg_in,
  output logic [kcv_pkg::MAG_W-1:0] quot,
  output logic                      neg_out
);
  import kcv_pkg::*;

  // each stage shifts dividend bits out of the top and quotient bits in at the bottom
  logic [MAG_W-1:0] word [DIV_STAGES];
  logic [7:0]       rem  [DIV_STAGES];
  logic             neg  [DIV_STAGES];
  logic [MAG_W-1:0] word_next [DIV_STAGES];
  logic [7:0]       rem_next  [DIV_STAGES];

  always_comb begin
    logic [MAG_W-1:0] w;
    logic [7:0]       r;
    logic [8:0]       t;
    for (int s = 0; s < DIV_STAGES; s++) begin
      w = (s == 0) ? mag_in : word[(s == 0) ? 0 : s - 1];
      r = (s == 0) ? 8'd0 : rem[(s == 0) ? 0 : s - 1];
      for (int k = 0; k < DIV_STEPS; k++) begin
        t = {r, w[MAG_W-1]};
        w = {w[MAG_W-2:0], 1'b0};
        if (t >= {1'b0, divisor}) begin
          t    = t - {1'b0, divisor};
          w[0] = 1'b1;
        end
        r = t[7:0];
      end
      word_next[s] = w;
      rem_next[s]  = r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        word[s] <= word_next[s];
        rem[s]  <= rem_next[s];
        neg[s]  <= (s == 0) ? neg_in : neg[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign quot    = word[DIV_STAGES-1];
  assign neg_out = neg[DIV_STAGES-1];

endmodule

// ===== src/kernel_convolution_3x3.sv =====
// throughput: one pixel per cycle while the skid slot is empty, set by the line stores and the
//   pipelined shift-subtract divider (4 quotient bits per stage, 7 stages)
// border pixels are consumed without producing a result
// reset (rst, synchronous): configuration to identity kernel, counters, window
//   and pipeline valid bits cleared; line stores are not cleared
module kernel_convolution_3x3 (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  kcv_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output kcv_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [23:0]    cfg_data
);
  import kcv_pkg::*;

  // configuration registers
  logic [23:0] coeff [KERNEL_SIZE];
  logic [7:0]  divisor;
  logic [15:0] offset;
  logic        color_mode;
  logic [10:0] image_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff[0]    <= 24'h000000;
      coeff[1]    <= 24'h000100;
      coeff[2]    <= 24'h000000;
      divisor     <= 8'd1;
      offset      <= 16'd0;
      color_mode  <= 1'b0;
      image_width <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COEFF_ROW0:  coeff[0]    <= cfg_data;
        CFG_COEFF_ROW1:  coeff[1]    <= cfg_data;
        CFG_COEFF_ROW2:  coeff[2]    <= cfg_data;
        CFG_DIVISOR:     divisor     <= cfg_data[7:0];
        CFG_OFFSET:      offset      <= cfg_data[15:0];
        CFG_COLOR_MODE:  color_mode  <= cfg_data[0];
        CFG_IMAGE_WIDTH: image_width <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; the skid slot frees the output side
  logic skid_valid;
  logic adv;
  logic acc;
  assign adv      = !skid_valid;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;

  // ---- stage 0: position counters ----
  logic [ADDR_W-1:0] col_cnt;
  logic [15:0]       row_cnt;
  logic [10:0]       w_eff;
  logic [10:0]       c_base;
  logic [15:0]       r_base;
  logic [ADDR_W-1:0] col_cur;
  logic [15:0]       row_cur;
  logic [10:0]       col_plus;
  logic [ADDR_W-1:0] col_cnt_next;
  logic [15:0]       row_cnt_next;
  logic              need_result;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  always_comb begin
    if (image_width < 11'd3)
      w_eff = 11'd3;
    else if (image_width > 11'(MAX_WIDTH))
      w_eff = 11'(MAX_WIDTH);
    else
      w_eff = image_width;
    c_base = in_data.start_of_frame ? 11'd0 : {1'b0, col_cnt};
    r_base = in_data.start_of_frame ? 16'd0 : row_cnt;
    // a count left at or past the width (after a width change) opens a new row
    if (c_base >= w_eff) begin
      col_cur = '0;
      row_cur = sat_inc(r_base);
    end else begin
      col_cur = c_base[ADDR_W-1:0];
      row_cur = r_base;
    end
    col_plus    = {1'b0, col_cur} + 11'd1;
    need_result = (row_cur >= 16'd2) && (col_cur >= ADDR_W'(2));
    if (in_data.end_of_frame) begin
      col_cnt_next = '0;
      row_cnt_next = 16'd0;
    end else if (col_plus >= w_eff) begin
      col_cnt_next = '0;
      row_cnt_next = sat_inc(row_cur);
    end else begin
      col_cnt_next = col_plus[ADDR_W-1:0];
      row_cnt_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= 16'd0;
    end else if (acc) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // ---- line stores ----
  logic [23:0]       store_a [MAX_WIDTH];
  logic [23:0]       store_b [MAX_WIDTH];
  logic [23:0]       rd_a;
  logic [23:0]       rd_b;
  logic              fwd_hit;
  logic [23:0]       fwd_val;
  logic              v1;
  logic [23:0]       s1_pix;
  logic [ADDR_W-1:0] s1_col;
  logic              s1_res;
  logic              s1_eof;

  // row above is written at transfer; the row two above is written later from the
  // value read, once it reaches stage 1, so a back-to-back hit on that column is forwarded
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_a             <= store_a[col_cur];
      rd_b             <= store_b[col_cur];
      store_a[col_cur] <= in_data.pixel_in;
      fwd_hit          <= v1 && (s1_col == col_cur);
      fwd_val          <= rd_a;
    end
    if (adv && v1)
      store_b[s1_col] <= rd_a;
  end

  // ---- stage 1 ----
  always_ff @(posedge clk) begin
    if (rst)
      v1 <= 1'b0;
    else if (adv)
      v1 <= acc;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix <= in_data.pixel_in;
      s1_col <= col_cur;
      s1_res <= need_result;
      s1_eof <= in_data.end_of_frame;
    end
  end

  // ---- stage 2: window ----
  logic [23:0] window [TAPS];
  logic [23:0] up2;
  logic        v2;
  logic        s2_eof;
  assign up2 = fwd_hit ? fwd_val : rd_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++)
        window[i] <= 24'd0;
    end else if (adv && v1) begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        window[r*KERNEL_SIZE]     <= window[r*KERNEL_SIZE + 1];
        window[r*KERNEL_SIZE + 1] <= window[r*KERNEL_SIZE + 2];
      end
      window[2]                 <= up2;
      window[KERNEL_SIZE + 2]   <= rd_a;
      window[2*KERNEL_SIZE + 2] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)
      v2 <= 1'b0;
    else if (adv)
      v2 <= v1 && s1_res;
  end

  always_ff @(posedge clk) begin
    if (adv)
      s2_eof <= s1_eof;
  end

  // ---- stage 3: products, lane 0 carries the 16-bit gray value (low byte in color mode) ----
  logic signed [PROD_W-1:0] prod      [LANES][TAPS];
  logic signed [PROD_W-1:0] prod_next [LANES][TAPS];
  logic                     v3;
  logic                     s3_eof;

  always_comb begin
    logic [15:0]              px;
    logic signed [7:0]        cf;
    logic signed [PROD_W-1:0] pxs;
    logic signed [PROD_W-1:0] cfs;
    for (int l = 0; l < LANES; l++) begin
      for (int t = 0; t < TAPS; t++) begin
        case (l)
          0:       px = color_mode ? {8'd0, window[t][7:0]} : window[t][15:0];
          1:       px = {8'd0, window[t][15:8]};
          default: px = {8'd0, window[t][23:16]};
        endcase
        cf = coeff[t / KERNEL_SIZE][8*(t % KERNEL_SIZE) +: 8];
        // operands at full product width so nothing is lost
        pxs = PROD_W'({1'b0, px});
        cfs = PROD_W'(cf);
        prod_next[l][t] = pxs * cfs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst)
      v3 <= 1'b0;
    else if (adv)
      v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod   <= prod_next;
      s3_eof <= s2_eof;
    end
  end

  // ---- stage 4: kernel row sums ----
  logic signed [ROW_W-1:0] rsum [LANES][KERNEL_SIZE];
  logic                    v4;
  logic                    s4_eof;

  always_ff @(posedge clk) begin
    if (rst)
      v4 <= 1'b0;
    else if (adv)
      v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++)
        for (int r = 0; r < KERNEL_SIZE; r++)
          rsum[l][r] <= ROW_W'(prod[l][r*KERNEL_SIZE]) +
                        ROW_W'(prod[l][r*KERNEL_SIZE + 1]) +
                        ROW_W'(prod[l][r*KERNEL_SIZE + 2]);
      s4_eof <= s3_eof;
    end
  end

  // ---- stage 5: total ----
  logic signed [SUM_W-1:0] total [LANES];
  logic                    v5;
  logic                    s5_eof;

  always_ff @(posedge clk) begin
    if (rst)
      v5 <= 1'b0;
    else if (adv)
      v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++)
        total[l] <= SUM_W'(rsum[l][0]) + SUM_W'(rsum[l][1]) + SUM_W'(rsum[l][2]);
      s5_eof <= s4_eof;
    end
  end

  // ---- stage 6: sign and magnitude for truncating division ----
  logic [MAG_W-1:0] mag [LANES];
  logic             neg [LANES];
  logic             v6;
  logic             s6_eof;

  always_ff @(posedge clk) begin
    if (rst)
      v6 <= 1'b0;
    else if (adv)
      v6 <= v5;
  end

  always_ff @(posedge clk) begin
    logic [SUM_W-1:0] a;
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        a      = total[l][SUM_W-1] ? SUM_W'(-total[l]) : SUM_W'(total[l]);
        mag[l] <= a[MAG_W-1:0];
        neg[l] <= total[l][SUM_W-1];
      end
      s6_eof <= s5_eof;
    end
  end

  // ---- dividers, one per lane ----
  logic [7:0]       div_eff;
  logic [MAG_W-1:0] quot  [LANES];
  logic             q_neg [LANES];
  logic             dv    [DIV_STAGES];
  logic             deof  [DIV_STAGES];
  assign div_eff = (divisor == 8'd0) ? 8'd1 : divisor;

  for (genvar l = 0; l < LANES; l++) begin : g_div
    kcv_div u_div (
      .clk     (clk),
      .en      (adv),
      .divisor (div_eff),
      .mag_in  (mag[l]),
      .neg_in  (neg[l]),
      .quot    (quot[l]),
      .neg_out (q_neg[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++)
        dv[s] <= 1'b0;
    end else if (adv) begin
      dv[0] <= v6;
      for (int s = 1; s < DIV_STAGES; s++)
        dv[s] <= dv[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      deof[0] <= s6_eof;
      for (int s = 1; s < DIV_STAGES; s++)
        deof[s] <= deof[s-1];
    end
  end

  // ---- offset, clamp at zero, saturate per channel ----
  logic        fin_valid;
  out_t        fin;
  logic [15:0] lane_res [LANES];

  always_comb begin
    logic signed [SUM_W-1:0] qs;
    logic signed [SUM_W:0]   v;
    logic [16:0]             maxv;
    for (int l = 0; l < LANES; l++) begin
      qs   = q_neg[l] ? -$signed({1'b0, quot[l]}) : $signed({1'b0, quot[l]});
      v    = (SUM_W+1)'(qs) + $signed({{(SUM_W-16){1'b0}}, offset});
      maxv = (l == 0 && !color_mode) ? 17'd65535 : 17'd255;
      if (v < 0)
        lane_res[l] = 16'd0;
      else if (v > $signed({{(SUM_W-16){1'b0}}, maxv}))
        lane_res[l] = maxv[15:0];
      else
        lane_res[l] = v[15:0];
    end
    fin_valid = dv[DIV_STAGES-1];
    if (color_mode)
      fin.pixel_out = {lane_res[2][7:0], lane_res[1][7:0], lane_res[0][7:0]};
    else
      fin.pixel_out = {8'd0, lane_res[0]};
    fin.last_out = deof[DIV_STAGES-1];
  end

  // ---- output register with skid slot ----
  out_t skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_data   <= skid;
        skid_valid <= 1'b0;
      end else if (fin_valid && adv) begin
        out_data <= fin;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (fin_valid && adv) begin
        out_data  <= fin;
        out_valid <= 1'b1;
      end
    end else if (fin_valid && adv) begin
      skid       <= fin;
      skid_valid <= 1'b1;
    end
  end

`ifndef SYNTH
  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output register empty");

  a_skid_fill_on_stall : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid slot filled without an output stall");

  a_window_held : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(window[2*KERNEL_SIZE + 2]))
    else $error("window moved during a stall");

  a_no_result_from_bubble : assert property (@(posedge clk) disable iff (rst)
    (adv && v2) |=> v3)
    else $error("result lost between window and product stages");
`endif

endmodule

// ===== verif/tb_kernel_convolution_3x3.sv =====
`timescale 1ns / 1ps

module tb_kernel_convolution_3x3;
  import kcv_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  kernel_convolution_3x3 dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // pixels waiting to be offered, and filtered pixels still owed by the block
  in_t  pixel_queue[$];
  out_t filtered_queue[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   long_hold_go = 0;

  // local copy of the configuration registers
  logic [23:0] k_row0, k_row1, k_row2;
  logic [7:0]  k_div;
  logic [15:0] k_offs;
  logic        k_rgb;
  logic [10:0] k_width;

  // local copy of the line stores, window and raster position
  logic [23:0] above1[MAX_WIDTH];
  logic [23:0] above2[MAX_WIDTH];
  logic [23:0] win[TAPS];
  int          col_pos, row_pos;

  function automatic longint filter_lane(int sh, longint msk, longint mx);
    longint      acc;
    longint      px;
    logic [23:0] wd;
    logic [7:0]  b;
    acc = 0;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      wd = (r == 0) ? k_row0 : ((r == 1) ? k_row1 : k_row2);
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        b = wd[8*c +: 8];
        px = longint'(win[r*KERNEL_SIZE + c] >> sh) & msk;
        acc += px * longint'($signed(b));
      end
    end
    // integer division truncates toward zero, as the hardware must
    acc = acc / longint'((k_div == 0) ? 8'd1 : k_div) + longint'(k_offs);
    if (acc < 0) acc = 0;
    if (acc > mx) acc = mx;
    return acc;
  endfunction

  // advance the raster model by one pixel and queue any filtered result
  function automatic void convolve_pixel(in_t px);
    int          w;
    int          c;
    logic [23:0] up1, up2;
    logic [23:0] res;
    out_t        o;
    w = int'(k_width);
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (px.start_of_frame) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      if (row_pos < 65535) row_pos++;
    end
    c = col_pos;
    up1 = above1[c];
    up2 = above2[c];
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      win[r*3 + 0] = win[r*3 + 1];
      win[r*3 + 1] = win[r*3 + 2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = px.pixel_in;
    above2[c] = up1;
    above1[c] = px.pixel_in;
    if (row_pos >= 2 && c >= 2) begin
      if (k_rgb) begin
        res[7:0]   = 8'(filter_lane(0, 255, 255));
        res[15:8]  = 8'(filter_lane(8, 255, 255));
        res[23:16] = 8'(filter_lane(16, 255, 255));
      end else begin
        res = 24'(filter_lane(0, 65535, 65535));
      end
      o.pixel_out = res;
      o.last_out = px.end_of_frame;
      filtered_queue.push_back(o);
    end
    if (px.end_of_frame) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        if (row_pos < 65535) row_pos++;
      end
    end
  endfunction

  // driver: offers queued pixels, predicts on each input transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) convolve_pixel(in_data);
      if (!in_valid || in_ready) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pixel_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, one long hold-off, compare each transfer
  int hold_cnt = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    out_t got, want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (filtered_queue.size() == 0) begin
          $error("unexpected result pixel_out=%h last_out=%b", got.pixel_out, got.last_out);
          errors++;
        end else begin
          want = filtered_queue.pop_front();
          if (got.pixel_out !== want.pixel_out) begin
            $error("pixel_out expected %h actual %h", want.pixel_out, got.pixel_out);
            errors++;
          end
          if (got.last_out !== want.last_out) begin
            $error("last_out expected %b actual %b", want.last_out, got.last_out);
            errors++;
          end
        end
      end
      if (long_hold_go && !hold_done) begin
        // block fills and must stall its input
        out_ready <= 1'b0;
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt >= 400) hold_done <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // run limit
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("tb_kernel_convolution_3x3: errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [23:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      CFG_COEFF_ROW0:  k_row0 = v;
      CFG_COEFF_ROW1:  k_row1 = v;
      CFG_COEFF_ROW2:  k_row2 = v;
      CFG_DIVISOR:     k_div = v[7:0];
      CFG_OFFSET:      k_offs = v[15:0];
      CFG_COLOR_MODE:  k_rgb = v[0];
      CFG_IMAGE_WIDTH: k_width = v[10:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [23:0] r0, logic [23:0] r1, logic [23:0] r2,
                           logic [7:0] dv, logic [15:0] of, logic rgb, int w);
    write_reg(CFG_COEFF_ROW0, r0);
    write_reg(CFG_COEFF_ROW1, r1);
    write_reg(CFG_COEFF_ROW2, r2);
    write_reg(CFG_DIVISOR, {16'd0, dv});
    write_reg(CFG_OFFSET, {8'd0, of});
    write_reg(CFG_COLOR_MODE, {23'd0, rgb});
    write_reg(CFG_IMAGE_WIDTH, 24'(w));
  endtask

  // wait for every owed result, then let border pixels drain
  task automatic drain();
    while (pixel_queue.size() > 0 || in_valid || filtered_queue.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_pixel(int style);
    case (style)
      1: return 24'h000000;
      2: return 24'hFFFFFF;
      default: begin
        case ($urandom_range(9))
          0: return 24'h000000;
          1: return 24'hFFFFFF;
          default: return 24'($urandom);
        endcase
      end
    endcase
  endfunction

  // one frame; noisy frames scatter start and end marks through the stream
  task automatic push_frame(int w, int rows, int style, bit noisy);
    in_t p;
    int  n;
    n = w * rows;
    for (int i = 0; i < n; i++) begin
      p.pixel_in = pick_pixel(style);
      p.start_of_frame = (i == 0) || (noisy && $urandom_range(24) == 0);
      p.end_of_frame = (i == n - 1) || (noisy && $urandom_range(24) == 0);
      pixel_queue.push_back(p);
    end
  endtask

  int pushed;
  int w, rows, phase;

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_COEFF_ROW0;
    cfg_data = '0;
    k_row0 = '0; k_row1 = 24'h000100; k_row2 = '0;
    k_div = 8'd1; k_offs = '0; k_rgb = 1'b0; k_width = 11'd1024;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      above1[i] = '0;
      above2[i] = '0;
    end
    for (int i = 0; i < TAPS; i++) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // identity kernel after reset, smallest width
    configure(24'h000000, 24'h000100, 24'h000000, 8'd1, 16'd0, 1'b0, 3);
    push_frame(3, 3, 2, 0);
    drain();
    // largest positive taps on full-scale gray: saturates
    configure(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 8'd1, 16'd0, 1'b0, 4);
    push_frame(4, 3, 2, 0);
    drain();
    // most negative taps in rgb: the full offset lifts it to saturation, then without offset it clamps to zero
    configure(24'h808080, 24'h808080, 24'h808080, 8'd255, 16'hFFFF, 1'b1, 4);
    push_frame(4, 3, 2, 0);
    drain();
    configure(24'h808080, 24'h808080, 24'h808080, 8'd1, 16'd0, 1'b1, 3);
    push_frame(3, 4, 2, 0);
    drain();
    // zero image and a negative divide that must truncate toward zero
    configure(24'hFF01FF, 24'h0102FF, 24'hFFFF01, 8'd7, 16'd0, 1'b0, 5);
    push_frame(5, 3, 1, 0);
    push_frame(5, 3, 0, 0);
    drain();

    // random phases, cycling the idle patterns
    pushed = 0;
    phase = 0;
    while (pushed < 1000 || phase < 3) begin
      case (phase % 3)
        0: begin send_idle_pct = 15; recv_idle_pct = 72; end
        1: begin send_idle_pct = 72; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      w = ($urandom_range(5) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 10);
      configure(24'($urandom), 24'($urandom), 24'($urandom),
                ($urandom_range(3) == 0) ? 8'(($urandom_range(1) == 0) ? 1 : 255)
                                         : 8'($urandom_range(1, 255)),
                ($urandom_range(3) == 0) ? 16'(($urandom_range(1) == 0) ? 0 : 65535)
                                         : 16'($urandom_range(0, 300)),
                1'($urandom_range(1)), w);
      if (phase == 2) long_hold_go = 1;
      for (int f = 0; f < 3; f++) begin
        rows = $urandom_range(3, 6);
        push_frame(w, rows, 0, ($urandom_range(4) == 0));
        pushed += w * rows;
      end
      // sender pauses here until every result has come
      drain();
      phase++;
    end

    // wide image, three rows
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(24'h010101, 24'h010201, 24'h010101, 8'd10, 16'd3, 1'b0, 200);
    push_frame(200, 3, 0, 0);
    drain();

    if (errors == 0) begin
      $display("tb_kernel_convolution_3x3: clean");
    end else begin
      $display("tb_kernel_convolution_3x3: errors");
    end
    $finish;
  end

endmodule
